// ----- rtl/asgr_pkg.sv -----
package asgr_pkg;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SGR_M = 8'h6D;

	// token ops from the front part
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_TEXT   = 3'd1;
	localparam logic [2:0] OP_OPEN   = 3'd2;
	localparam logic [2:0] OP_SEP    = 3'd3;
	localparam logic [2:0] OP_DIGIT  = 3'd4;
	localparam logic [2:0] OP_COMMIT = 3'd5;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_TEXT   = 2'd1;
	localparam logic [1:0] KIND_COMMIT = 2'd2;

	localparam logic [15:0] FG_MASK  = 16'h000F;
	localparam logic [15:0] BG_MASK  = 16'h0070;
	localparam logic [15:0] FG_COLOR = 16'h0007;
	localparam logic [15:0] FG_INT   = 16'h0008;
	localparam logic [15:0] BG_INT   = 16'h0080;
	localparam logic [15:0] REV_BIT  = 16'h4000;
	localparam logic [15:0] UND_BIT  = 16'h8000;

	localparam logic [2:0] SKIP_NONE = 3'd0;
	localparam logic [2:0] SKIP_SEL  = 3'd1;
	localparam logic [2:0] SKIP_ONE  = 3'd2;
	localparam logic [2:0] SKIP_THREE = 3'd4;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] text_byte;
		logic       eot;
	} token_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  text_byte;
		logic [15:0] attr;
		logic        restored;
	} result_t;

	typedef struct packed {
		logic [15:0] attr;
		logic        bold;
		logic [2:0]  skip;
	} pend_t;

	function automatic logic [2:0] color_map(input logic [2:0] idx);
		logic [2:0] c;
		case (idx)
			3'd0: c = 3'd0;
			3'd1: c = 3'd4;
			3'd2: c = 3'd2;
			3'd3: c = 3'd6;
			3'd4: c = 3'd1;
			3'd5: c = 3'd5;
			3'd6: c = 3'd3;
			default: c = 3'd7;
		endcase
		return c;
	endfunction

	// one SGR parameter applied to the pending attribute
	function automatic pend_t apply_param(input logic [7:0] p, input pend_t cur,
			input logic [15:0] orig);
		pend_t r;
		logic [7:0] off;
		r = cur;
		off = 8'd0;
		if (cur.skip == SKIP_SEL) begin
			r.skip = (p == 8'd2) ? SKIP_THREE : (p == 8'd5) ? SKIP_ONE : SKIP_NONE;
		end else if (cur.skip != SKIP_NONE) begin
			r.skip = (cur.skip == SKIP_ONE) ? SKIP_NONE : cur.skip - 3'd1;
		end else begin
			case (p) inside
				8'd0: begin
					r.attr = orig;
					r.bold = 1'b0;
				end
				8'd1: begin
					r.attr = cur.attr | FG_INT;
					r.bold = 1'b1;
				end
				8'd4:  r.attr = cur.attr | UND_BIT;
				8'd7:  r.attr = cur.attr | REV_BIT;
				8'd22: r.attr = cur.attr & ~FG_INT;
				8'd24: r.attr = cur.attr & ~UND_BIT;
				8'd27: r.attr = cur.attr & ~REV_BIT;
				[8'd30:8'd37]: begin
					off = p - 8'd30;
					r.attr = (cur.attr & ~FG_MASK) | {13'd0, color_map(off[2:0])}
						| (cur.bold ? FG_INT : 16'd0);
				end
				8'd38, 8'd48: r.skip = SKIP_SEL;
				8'd39: r.attr = (cur.attr & ~FG_COLOR) | (orig & FG_COLOR);
				[8'd40:8'd47]: begin
					off = p - 8'd40;
					r.attr = (cur.attr & ~BG_MASK) | {9'd0, color_map(off[2:0]), 4'd0};
				end
				8'd49: r.attr = (cur.attr & ~BG_MASK) | (orig & BG_MASK);
				[8'd90:8'd97]: begin
					off = p - 8'd90;
					r.attr = (cur.attr & ~FG_COLOR) | {13'd0, color_map(off[2:0])} | FG_INT;
				end
				[8'd100:8'd107]: begin
					off = p - 8'd100;
					r.attr = (cur.attr & ~BG_MASK) | {9'd0, color_map(off[2:0]), 4'd0}
						| BG_INT;
				end
				default: r = cur;
			endcase
		end
		return r;
	endfunction

endpackage

// ----- rtl/asgr_fifo.sv -----
module asgr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/asgr_front.sv -----
module asgr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        text_byte,
	input  logic              end_of_text,
	output asgr_pkg::token_t  token
);

	localparam logic [2:0] M_TEXT    = 3'd0;
	localparam logic [2:0] M_ESC     = 3'd1;
	localparam logic [2:0] M_CSI     = 3'd2;
	localparam logic [2:0] M_OSC     = 3'd3;
	localparam logic [2:0] M_OSC_ESC = 3'd4;

	logic [2:0] mode_q;
	logic [2:0] mode_nxt;
	logic [2:0] op;

	always_comb begin
		mode_nxt = mode_q;
		op       = asgr_pkg::OP_NONE;
		unique case (mode_q)
			M_TEXT: begin
				if (text_byte == asgr_pkg::CH_ESC) begin
					mode_nxt = M_ESC;
				end else begin
					op = asgr_pkg::OP_TEXT;
				end
			end
			M_ESC: begin
				if (text_byte == asgr_pkg::CH_LBRK) begin
					mode_nxt = M_CSI;
					op       = asgr_pkg::OP_OPEN;
				end else if (text_byte == asgr_pkg::CH_RBRK) begin
					mode_nxt = M_OSC;
				end else begin
					mode_nxt = M_TEXT;
				end
			end
			M_CSI: begin
				if (text_byte == asgr_pkg::CH_SEMI) begin
					op = asgr_pkg::OP_SEP;
				end else if (text_byte >= asgr_pkg::CH_ZERO && text_byte <= asgr_pkg::CH_NINE) begin
					op = asgr_pkg::OP_DIGIT;
				end else if (text_byte == asgr_pkg::CH_SGR_M) begin
					op       = asgr_pkg::OP_COMMIT;
					mode_nxt = M_TEXT;
				end else begin
					mode_nxt = M_TEXT;
				end
			end
			M_OSC: begin
				if (text_byte == asgr_pkg::CH_ESC) begin
					mode_nxt = M_OSC_ESC;
				end
			end
			M_OSC_ESC: begin
				if (text_byte == asgr_pkg::CH_BSL) begin
					mode_nxt = M_TEXT;
				end else if (text_byte != asgr_pkg::CH_ESC) begin
					mode_nxt = M_OSC;
				end
			end
			default: mode_nxt = M_TEXT;
		endcase
		if (end_of_text) begin
			mode_nxt = M_TEXT;
		end
	end

	assign token.op        = op;
	assign token.text_byte = text_byte;
	assign token.eot       = end_of_text;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_TEXT;
		end else if (take) begin
			mode_q <= mode_nxt;
		end
	end

endmodule

// ----- rtl/asgr_back.sv -----
module asgr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	input  logic              run,
	input  asgr_pkg::token_t  token,
	output asgr_pkg::result_t result
);

	logic [15:0]     orig_q;
	logic [15:0]     cur_attr_q;
	logic            cur_bold_q;
	asgr_pkg::pend_t pend_q;
	logic [7:0]      param_q;
	asgr_pkg::pend_t applied;
	logic [11:0]     acc;
	logic [3:0]      digit;
	logic [7:0]      diff;

	assign applied = asgr_pkg::apply_param(param_q, pend_q, orig_q);
	assign diff    = token.text_byte - asgr_pkg::CH_ZERO;
	assign digit   = diff[3:0];
	// param * 10 + digit, max 2559
	assign acc     = {1'b0, param_q, 3'd0} + {3'd0, param_q, 1'b0} + {8'd0, digit};

	always_comb begin
		result.kind      = asgr_pkg::KIND_NONE;
		result.text_byte = 8'd0;
		result.attr      = cur_attr_q;
		result.restored  = token.eot;
		case (token.op)
			asgr_pkg::OP_TEXT: begin
				result.kind      = asgr_pkg::KIND_TEXT;
				result.text_byte = token.text_byte;
			end
			asgr_pkg::OP_COMMIT: begin
				result.kind = asgr_pkg::KIND_COMMIT;
				result.attr = applied.attr;
			end
			default: ;
		endcase
	end

	// end of text drops any open sequence; pending attr is reloaded at the next open
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orig_q     <= 16'h0007;
			cur_attr_q <= 16'h0007;
			cur_bold_q <= 1'b0;
			param_q    <= 8'd0;
			pend_q     <= '{attr: 16'h0000, bold: 1'b0, skip: asgr_pkg::SKIP_NONE};
		end else if (cfg_we) begin
			orig_q     <= cfg_data;
			cur_attr_q <= cfg_data;
			cur_bold_q <= 1'b0;
		end else if (run) begin
			if (token.eot) begin
				cur_attr_q  <= orig_q;
				cur_bold_q  <= 1'b0;
				param_q     <= 8'd0;
				pend_q.skip <= asgr_pkg::SKIP_NONE;
			end else begin
				case (token.op)
					asgr_pkg::OP_OPEN: begin
						param_q <= 8'd0;
						pend_q  <= '{attr: cur_attr_q, bold: cur_bold_q,
							skip: asgr_pkg::SKIP_NONE};
					end
					asgr_pkg::OP_SEP: begin
						param_q <= 8'd0;
						pend_q  <= applied;
					end
					asgr_pkg::OP_DIGIT: begin
						param_q <= (acc > 12'd255) ? 8'hFF : acc[7:0];
					end
					asgr_pkg::OP_COMMIT: begin
						pend_q     <= applied;
						cur_attr_q <= applied.attr;
						cur_bold_q <= applied.bold;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- rtl/ansi_sgr_to_text_attribute_core.sv -----
// Text byte stream to attributed text. One byte is taken per clock when the
// input queue is not full, and every byte yields exactly one result: a text byte
// with its 16-bit attribute, an attribute commit at the 'm' that closes an SGR
// sequence, or an empty entry for bytes the escape parser swallows. The front
// tracks escape/CSI/OSC mode, a QUEUE_DEPTH-entry queue decouples it from the
// back, which keeps the attribute state and applies SGR parameters, and a
// second queue of the same depth holds results. Sustained rate is one byte per
// cycle unless the result queue fills; results reach the ports via both queues.
// Write orig_attr only while idle: it also loads the current attribute.
module ansi_sgr_to_text_attribute_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic [15:0] out_attr,
	output logic        restored,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	asgr_pkg::token_t  fe_token;
	asgr_pkg::token_t  be_token;
	asgr_pkg::result_t be_result;
	asgr_pkg::result_t out_result;
	logic              take;
	logic              mid_full;
	logic              mid_empty;
	logic              out_full;
	logic              run;

	assign cfg_ready = 1'b1;
	assign full      = mid_full;
	assign take      = push && !mid_full;
	assign run       = !mid_empty && !out_full;

	asgr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.token       (fe_token)
	);

	asgr_fifo #(
		.WIDTH ($bits(asgr_pkg::token_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (fe_token),
		.full   (mid_full),
		.pop    (run),
		.rdata  (be_token),
		.empty  (mid_empty)
	);

	asgr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.run      (run),
		.token    (be_token),
		.result   (be_result)
	);

	asgr_fifo #(
		.WIDTH ($bits(asgr_pkg::result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (run),
		.wdata  (be_result),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_result),
		.empty  (empty)
	);

	assign out_kind = out_result.kind;
	assign out_byte = out_result.text_byte;
	assign out_attr = out_result.attr;
	assign restored = out_result.restored;

`ifndef SYNTHESIS
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_kind == asgr_pkg::KIND_NONE || out_kind == asgr_pkg::KIND_TEXT
			|| out_kind == asgr_pkg::KIND_COMMIT))
		else $error("illegal result kind");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_kind != asgr_pkg::KIND_TEXT) |-> (out_byte == 8'd0))
		else $error("byte set on non-text result");

	a_back_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(run && !pop) |=> !empty)
		else $error("result lost after back-end step");

	a_commit_from_csi: assert property (@(posedge clk) disable iff (!arst_n)
		(run && be_token.op == asgr_pkg::OP_COMMIT) |-> (be_result.kind == asgr_pkg::KIND_COMMIT))
		else $error("commit token without commit result");
`endif

endmodule
